@@ hw/rtl/first_fit_heap_allocator_unit_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Used by ffha_datapath and ffha_ctrl; no other dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define FFHA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ffha_pkg.sv @@
// Types and fixed constants of the first-fit heap allocator.
// Used by ffha_datapath, ffha_ctrl and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

    localparam int ADDR_W     = 32;
    localparam int REQ_W      = 25;
    localparam int OFF_W      = 25;
    localparam int SIZE_W     = 25;
    localparam int SZ_W       = 26;
    localparam int DATA_W     = 64;
    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0040_0000;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NULL    = 2'd1,
        ST_OOM     = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic              free;
    } t_entry;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_INIT,
        DP_LOAD,
        DP_SET_NULL,
        DP_SET_UNKNOWN,
        DP_SET_OOM,
        DP_SCAN_RD,
        DP_SCAN_NEXT,
        DP_HIT,
        DP_GROW_SIZE,
        DP_LAST_RD,
        DP_GROW,
        DP_TAKE,
        DP_SH_RD,
        DP_SH_WR,
        DP_SPLIT,
        DP_COMMIT,
        DP_FREE_MARK,
        DP_MG_RD0,
        DP_MG_LOAD,
        DP_MG_RD,
        DP_MG_EV,
        DP_MG_END,
        DP_PUBLISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic req_null;
        logic is_free;
        logic at_end;
        logic hit;
        logic oom;
        logic split;
        logic shift_more;
    } t_dp_stat;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_EV,
        S_UNKNOWN,
        S_GROW_SIZE,
        S_GROW_DEC,
        S_GROW_WR,
        S_TAKE,
        S_SH_CHK,
        S_SH_RD,
        S_SH_WR,
        S_SPLIT,
        S_COMMIT,
        S_FREE_MARK,
        S_MG_RD0,
        S_MG_LOAD,
        S_MG_CHK,
        S_MG_EV,
        S_MG_END,
        S_DONE
    } t_ctrl_state;

endpackage

`default_nettype wire

@@ hw/rtl/ffha_datapath.sv @@
// Datapath: block table memory, counters, page rounding and result registers.
// Depends on ffha_pkg and first_fit_heap_allocator_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_heap_allocator_unit_macros.svh"

module ffha_datapath #(
    parameter int MAX_BLOCKS     = 64,
    parameter int HEADER_BYTES   = 24,
    parameter int PAGE_BYTES     = 4096,
    parameter int HEAP_CAP_BYTES = 16777216
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [ffha_pkg::ADDR_W-1:0]   i_cfg_wr_data,
    input  wire logic                          i_req_op,
    input  wire logic [ffha_pkg::DATA_W-1:0]   i_req_data,
    input  ffha_pkg::t_dp_cmd                  i_cmd,
    output ffha_pkg::t_dp_stat                 o_stat,
    output logic [ffha_pkg::DATA_W-1:0]        o_res_data
);

    localparam int CW  = $clog2(MAX_BLOCKS + 1);
    localparam int IW  = $clog2(MAX_BLOCKS);
    localparam int HDR = (HEADER_BYTES + 7) & ~7;

    ffha_pkg::t_entry r_mem [MAX_BLOCKS];
    ffha_pkg::t_entry r_rd_data;
    ffha_pkg::t_entry r_acc;
    ffha_pkg::t_entry n_acc;
    ffha_pkg::t_entry w_wr_data;
    logic             w_rd_en;
    logic             w_wr_en;
    logic [IW-1:0]    w_rd_addr;
    logic [IW-1:0]    w_wr_addr;

    logic [ffha_pkg::ADDR_W-1:0]  r_base;
    logic [CW-1:0]                r_count;
    logic [ffha_pkg::SIZE_W-1:0]  r_committed;
    logic [ffha_pkg::SIZE_W-1:0]  r_total;
    logic                         r_is_free;
    logic                         r_req_zero;
    logic [ffha_pkg::SZ_W-1:0]    r_sz;
    logic [ffha_pkg::ADDR_W-1:0]  r_addr;
    logic [CW-1:0]                r_idx;
    logic [CW-1:0]                r_wr;
    logic [ffha_pkg::ADDR_W-1:0]  r_grow;
    logic [ffha_pkg::ADDR_W-1:0]  r_res_addr;
    ffha_pkg::t_status            r_res_status;
    logic [ffha_pkg::ADDR_W-1:0]  r_o_addr;
    ffha_pkg::t_status            r_o_status;
    logic [ffha_pkg::SIZE_W-1:0]  r_o_used;

    logic [ffha_pkg::REQ_W-1:0]   w_req;
    logic [ffha_pkg::ADDR_W-1:0]  w_addr;
    logic                         w_op_free;
    logic [ffha_pkg::ADDR_W-1:0]  w_rd_payload;
    logic [ffha_pkg::ADDR_W-1:0]  w_acc_payload;
    logic                         w_merge;
    logic [CW-1:0]                w_wr_m1;
    logic [CW-1:0]                w_cnt_m1;
    logic [CW-1:0]                w_idx_p1;

    assign w_req         = i_req_data[ffha_pkg::REQ_W-1:0];
    assign w_addr        = i_req_data[ffha_pkg::REQ_W+ffha_pkg::ADDR_W-1:ffha_pkg::REQ_W];
    assign w_op_free     = i_req_op == ffha_pkg::OP_FREE;
    assign w_rd_payload  = r_base + ffha_pkg::ADDR_W'(r_rd_data.off) + ffha_pkg::ADDR_W'(HDR);
    assign w_acc_payload = r_base + ffha_pkg::ADDR_W'(r_acc.off) + ffha_pkg::ADDR_W'(HDR);
    assign w_merge       = r_acc.free && r_rd_data.free;
    assign w_wr_m1       = r_wr - CW'(1);
    assign w_cnt_m1      = r_count - CW'(1);
    assign w_idx_p1      = r_idx + CW'(1);

    always_comb begin
        o_stat.req_null   = r_req_zero;
        o_stat.is_free    = r_is_free;
        o_stat.at_end     = r_idx >= r_count;
        o_stat.hit        = r_is_free ? (!r_rd_data.free && w_rd_payload == r_addr)
                                      : (r_rd_data.free &&
                                         {1'b0, r_rd_data.size} >= r_sz);
        o_stat.oom        = (r_count >= CW'(MAX_BLOCKS)) ||
                            (ffha_pkg::ADDR_W'(r_committed) + r_grow >
                             ffha_pkg::ADDR_W'(HEAP_CAP_BYTES));
        o_stat.split      = (ffha_pkg::ADDR_W'(r_acc.size) >=
                             ffha_pkg::ADDR_W'(r_sz) + ffha_pkg::ADDR_W'(HDR + 8)) &&
                            (r_count < CW'(MAX_BLOCKS));
        o_stat.shift_more = r_wr > w_idx_p1;
    end

    // Table port selection and next accumulator value
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx[IW-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx[IW-1:0];
        w_wr_data = r_acc;
        n_acc     = r_acc;
        case (i_cmd.op)
            ffha_pkg::DP_INIT: begin
                w_wr_en        = 1'b1;
                w_wr_addr      = '0;
                w_wr_data.off  = '0;
                w_wr_data.size = ffha_pkg::SIZE_W'(PAGE_BYTES - HDR);
                w_wr_data.free = 1'b1;
            end
            ffha_pkg::DP_SCAN_RD, ffha_pkg::DP_MG_RD: begin
                w_rd_en = 1'b1;
            end
            ffha_pkg::DP_MG_RD0: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
            end
            ffha_pkg::DP_LAST_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_cnt_m1[IW-1:0];
            end
            ffha_pkg::DP_HIT, ffha_pkg::DP_MG_LOAD: begin
                n_acc = r_rd_data;
            end
            ffha_pkg::DP_GROW: begin
                n_acc.off  = r_rd_data.off + ffha_pkg::OFF_W'(HDR) + r_rd_data.size;
                n_acc.size = ffha_pkg::SIZE_W'(r_grow - ffha_pkg::ADDR_W'(HDR));
                n_acc.free = 1'b1;
                w_wr_en    = 1'b1;
                w_wr_addr  = r_count[IW-1:0];
                w_wr_data  = n_acc;
            end
            ffha_pkg::DP_SH_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_wr_m1[IW-1:0];
            end
            ffha_pkg::DP_SH_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_wr[IW-1:0];
                w_wr_data = r_rd_data;
            end
            ffha_pkg::DP_SPLIT: begin
                w_wr_en        = 1'b1;
                w_wr_addr      = w_idx_p1[IW-1:0];
                w_wr_data.off  = r_acc.off + ffha_pkg::OFF_W'(HDR) + ffha_pkg::OFF_W'(r_sz);
                w_wr_data.size = r_acc.size - ffha_pkg::SIZE_W'(r_sz) -
                                 ffha_pkg::SIZE_W'(HDR);
                w_wr_data.free = 1'b1;
                n_acc.size     = ffha_pkg::SIZE_W'(r_sz);
            end
            ffha_pkg::DP_COMMIT: begin
                w_wr_en        = 1'b1;
                w_wr_data.free = 1'b0;
            end
            ffha_pkg::DP_FREE_MARK: begin
                w_wr_en        = 1'b1;
                w_wr_data.free = 1'b1;
            end
            ffha_pkg::DP_MG_EV: begin
                if (w_merge) begin
                    n_acc.size = r_acc.size + ffha_pkg::SIZE_W'(HDR) + r_rd_data.size;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_wr[IW-1:0];
                    n_acc     = r_rd_data;
                end
            end
            ffha_pkg::DP_MG_END: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_wr[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= ffha_pkg::BASE_RESET;
            r_count     <= CW'(1);
            r_committed <= ffha_pkg::SIZE_W'(PAGE_BYTES);
            r_total     <= '0;
            r_o_addr    <= '0;
            r_o_status  <= ffha_pkg::ST_DONE;
            r_o_used    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_base <= i_cfg_wr_data;
            end
            case (i_cmd.op)
                ffha_pkg::DP_GROW: begin
                    r_count     <= r_count + CW'(1);
                    r_committed <= r_committed + ffha_pkg::SIZE_W'(r_grow);
                end
                ffha_pkg::DP_SPLIT: begin
                    r_count <= r_count + CW'(1);
                end
                ffha_pkg::DP_COMMIT: begin
                    r_total <= r_total + r_acc.size;
                end
                ffha_pkg::DP_FREE_MARK: begin
                    r_total <= r_total - r_acc.size;
                end
                ffha_pkg::DP_MG_END: begin
                    r_count <= r_wr + CW'(1);
                end
                ffha_pkg::DP_PUBLISH: begin
                    r_o_addr   <= r_res_addr;
                    r_o_status <= r_res_status;
                    r_o_used   <= r_total;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        case (i_cmd.op)
            ffha_pkg::DP_LOAD: begin
                r_is_free  <= w_op_free;
                r_req_zero <= w_op_free ? (w_addr == '0) : (w_req == '0);
                r_sz       <= ({1'b0, w_req} + ffha_pkg::SZ_W'(7)) & ~ffha_pkg::SZ_W'(7);
                r_addr     <= w_addr;
                r_idx      <= '0;
            end
            ffha_pkg::DP_SCAN_NEXT: begin
                r_idx <= w_idx_p1;
            end
            ffha_pkg::DP_SET_NULL: begin
                r_res_addr   <= '0;
                r_res_status <= ffha_pkg::ST_NULL;
            end
            ffha_pkg::DP_SET_UNKNOWN: begin
                r_res_addr   <= '0;
                r_res_status <= ffha_pkg::ST_UNKNOWN;
            end
            ffha_pkg::DP_SET_OOM: begin
                r_res_addr   <= '0;
                r_res_status <= ffha_pkg::ST_OOM;
            end
            ffha_pkg::DP_GROW_SIZE: begin
                // round header plus payload up to whole pages
                r_grow <= (ffha_pkg::ADDR_W'(r_sz) + ffha_pkg::ADDR_W'(HDR + PAGE_BYTES - 1)) &
                          ~ffha_pkg::ADDR_W'(PAGE_BYTES - 1);
            end
            ffha_pkg::DP_GROW: begin
                r_idx <= r_count;
            end
            ffha_pkg::DP_TAKE: begin
                r_wr <= r_count;
            end
            ffha_pkg::DP_SH_WR: begin
                r_wr <= w_wr_m1;
            end
            ffha_pkg::DP_COMMIT: begin
                r_res_addr   <= w_acc_payload;
                r_res_status <= ffha_pkg::ST_DONE;
            end
            ffha_pkg::DP_MG_LOAD: begin
                r_idx <= CW'(1);
                r_wr  <= '0;
            end
            ffha_pkg::DP_MG_EV: begin
                r_idx <= w_idx_p1;
                if (!w_merge) begin
                    r_wr <= r_wr + CW'(1);
                end
            end
            ffha_pkg::DP_MG_END: begin
                r_res_addr   <= '0;
                r_res_status <= ffha_pkg::ST_DONE;
            end
            default: begin
            end
        endcase
    end

    assign o_res_data = {5'd0, r_o_used, r_o_status, r_o_addr};

    `FFHA_ASSERT_ALWAYS(a_used_within_heap, i_clk, i_rst_n, r_total <= r_committed, "used bytes exceed committed heap")
    `FFHA_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, (r_count != '0) && (r_count <= CW'(MAX_BLOCKS)), "block count out of range")
    `FFHA_ASSERT_ALWAYS(a_split_has_room, i_clk, i_rst_n, (i_cmd.op != ffha_pkg::DP_SPLIT) || (r_count < CW'(MAX_BLOCKS)), "split with full table")

endmodule

`default_nettype wire

@@ hw/rtl/ffha_ctrl.sv @@
// Controller state machine: sequences table scans, growth, split and merge passes.
// Depends on ffha_pkg and first_fit_heap_allocator_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_heap_allocator_unit_macros.svh"

module ffha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_valid,
    output logic               o_s_ready,
    output logic               o_m_valid,
    input  wire logic          i_m_ready,
    input  ffha_pkg::t_dp_stat i_stat,
    output ffha_pkg::t_dp_cmd  o_cmd
);

    ffha_pkg::t_ctrl_state r_state;
    ffha_pkg::t_ctrl_state n_state;
    logic                  r_m_valid;
    logic                  n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ffha_pkg::S_INIT;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid && !i_m_ready;
        o_cmd.op  = ffha_pkg::DP_NOP;
        o_s_ready = 1'b0;
        case (r_state)
            ffha_pkg::S_INIT: begin
                o_cmd.op = ffha_pkg::DP_INIT;
                n_state  = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.op = ffha_pkg::DP_LOAD;
                    n_state  = ffha_pkg::S_DISPATCH;
                end
            end
            ffha_pkg::S_DISPATCH: begin
                if (i_stat.req_null) begin
                    o_cmd.op = ffha_pkg::DP_SET_NULL;
                    n_state  = ffha_pkg::S_DONE;
                end else begin
                    n_state = ffha_pkg::S_SCAN_RD;
                end
            end
            ffha_pkg::S_SCAN_RD: begin
                if (i_stat.at_end) begin
                    n_state = i_stat.is_free ? ffha_pkg::S_UNKNOWN : ffha_pkg::S_GROW_SIZE;
                end else begin
                    o_cmd.op = ffha_pkg::DP_SCAN_RD;
                    n_state  = ffha_pkg::S_SCAN_EV;
                end
            end
            ffha_pkg::S_SCAN_EV: begin
                if (i_stat.hit) begin
                    o_cmd.op = ffha_pkg::DP_HIT;
                    n_state  = i_stat.is_free ? ffha_pkg::S_FREE_MARK : ffha_pkg::S_TAKE;
                end else begin
                    o_cmd.op = ffha_pkg::DP_SCAN_NEXT;
                    n_state  = ffha_pkg::S_SCAN_RD;
                end
            end
            ffha_pkg::S_UNKNOWN: begin
                o_cmd.op = ffha_pkg::DP_SET_UNKNOWN;
                n_state  = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_GROW_SIZE: begin
                o_cmd.op = ffha_pkg::DP_GROW_SIZE;
                n_state  = ffha_pkg::S_GROW_DEC;
            end
            ffha_pkg::S_GROW_DEC: begin
                if (i_stat.oom) begin
                    o_cmd.op = ffha_pkg::DP_SET_OOM;
                    n_state  = ffha_pkg::S_DONE;
                end else begin
                    o_cmd.op = ffha_pkg::DP_LAST_RD;
                    n_state  = ffha_pkg::S_GROW_WR;
                end
            end
            ffha_pkg::S_GROW_WR: begin
                o_cmd.op = ffha_pkg::DP_GROW;
                n_state  = ffha_pkg::S_TAKE;
            end
            ffha_pkg::S_TAKE: begin
                o_cmd.op = ffha_pkg::DP_TAKE;
                n_state  = i_stat.split ? ffha_pkg::S_SH_CHK : ffha_pkg::S_COMMIT;
            end
            ffha_pkg::S_SH_CHK: begin
                // open a slot after the chosen block
                n_state = i_stat.shift_more ? ffha_pkg::S_SH_RD : ffha_pkg::S_SPLIT;
            end
            ffha_pkg::S_SH_RD: begin
                o_cmd.op = ffha_pkg::DP_SH_RD;
                n_state  = ffha_pkg::S_SH_WR;
            end
            ffha_pkg::S_SH_WR: begin
                o_cmd.op = ffha_pkg::DP_SH_WR;
                n_state  = ffha_pkg::S_SH_CHK;
            end
            ffha_pkg::S_SPLIT: begin
                o_cmd.op = ffha_pkg::DP_SPLIT;
                n_state  = ffha_pkg::S_COMMIT;
            end
            ffha_pkg::S_COMMIT: begin
                o_cmd.op = ffha_pkg::DP_COMMIT;
                n_state  = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_FREE_MARK: begin
                o_cmd.op = ffha_pkg::DP_FREE_MARK;
                n_state  = ffha_pkg::S_MG_RD0;
            end
            ffha_pkg::S_MG_RD0: begin
                o_cmd.op = ffha_pkg::DP_MG_RD0;
                n_state  = ffha_pkg::S_MG_LOAD;
            end
            ffha_pkg::S_MG_LOAD: begin
                o_cmd.op = ffha_pkg::DP_MG_LOAD;
                n_state  = ffha_pkg::S_MG_CHK;
            end
            ffha_pkg::S_MG_CHK: begin
                if (i_stat.at_end) begin
                    n_state = ffha_pkg::S_MG_END;
                end else begin
                    o_cmd.op = ffha_pkg::DP_MG_RD;
                    n_state  = ffha_pkg::S_MG_EV;
                end
            end
            ffha_pkg::S_MG_EV: begin
                o_cmd.op = ffha_pkg::DP_MG_EV;
                n_state  = ffha_pkg::S_MG_CHK;
            end
            ffha_pkg::S_MG_END: begin
                o_cmd.op = ffha_pkg::DP_MG_END;
                n_state  = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_DONE: begin
                // hold until the output slot is free
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.op  = ffha_pkg::DP_PUBLISH;
                    n_m_valid = 1'b1;
                    n_state   = ffha_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffha_pkg::S_IDLE;
            end
        endcase
    end

    assign o_m_valid = r_m_valid;

    `FFHA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_s_valid && o_s_ready, r_state != ffha_pkg::S_IDLE, "request accepted but controller stayed idle")
    `FFHA_ASSERT_NEXT(a_publish_sets_valid, i_clk, i_rst_n, o_cmd.op == ffha_pkg::DP_PUBLISH, r_m_valid, "published result not presented")
    `FFHA_ASSERT_NEXT(a_init_once, i_clk, i_rst_n, r_state == ffha_pkg::S_INIT, r_state == ffha_pkg::S_IDLE, "table init did not finish")

endmodule

`default_nettype wire

@@ hw/rtl/first_fit_heap_allocator_unit.sv @@
// First-fit heap allocator, top level: stream ports, config register, controller and datapath.
// Depends on ffha_pkg, ffha_ctrl and ffha_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Serves allocate and free requests over an address-ordered block table held in a
// single-port memory of MAX_BLOCKS entries, one read or one write per cycle. Right
// after reset the table is set to a single free page; no request is taken until that
// is done. Requests are handled one at a time. An allocation scans table entries in
// order up to the first fit; on a split it moves entries up to open a slot after the
// chosen block and then writes the split-off remainder there. A miss scans the whole
// table, then rounds the size up to whole pages and grows the heap. PAGE_BYTES must be
// a power of two. A free scans the entries to find the block and then runs a merge
// sweep over the whole table. A request may also wait for the previous result to
// leave the output register.

module first_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS     = 64,
    parameter int HEADER_BYTES   = 24,
    parameter int PAGE_BYTES     = 4096,
    parameter int HEAP_CAP_BYTES = 16777216
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [ffha_pkg::ADDR_W-1:0] i_cfg_wr_data,  // heap_base
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic                        s_axis_tuser,   // operation
    // request_bytes[24:0], free_address[56:25], zero pad
    input  wire logic [ffha_pkg::DATA_W-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // payload_address[31:0], status[33:32], live_bytes[58:34], zero pad
    output logic [ffha_pkg::DATA_W-1:0]      m_axis_tdata
);

    ffha_pkg::t_dp_cmd  w_cmd;
    ffha_pkg::t_dp_stat w_stat;

    ffha_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    ffha_datapath #(
        .MAX_BLOCKS     (MAX_BLOCKS),
        .HEADER_BYTES   (HEADER_BYTES),
        .PAGE_BYTES     (PAGE_BYTES),
        .HEAP_CAP_BYTES (HEAP_CAP_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req_op      (s_axis_tuser),
        .i_req_data    (s_axis_tdata),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_res_data    (m_axis_tdata)
    );

endmodule

`default_nettype wire
